[rtl/jer_pkg.sv]
// jer_pkg: shared types and character codes for the jis escape repair block
// no dependencies

package jer_pkg;

    typedef logic [7:0] t_byte;

    // shift sequence characters
    localparam t_byte CH_ESC    = 8'h1B;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_PAREN  = 8'h28;
    localparam t_byte CH_AT     = 8'h40;
    localparam t_byte CH_B      = 8'h42;
    localparam t_byte CH_H      = 8'h48;
    localparam t_byte CH_J      = 8'h4A;

    // most bytes one request can produce
    localparam int GRP_DEPTH = 3;

    typedef logic [1:0] t_grp_cnt;

    // what is pending from earlier requests
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ESC1    = 3'd1,
        ST_DOLLAR  = 3'd2,
        ST_ESC_DOL = 3'd3,
        ST_ESC2    = 3'd4,
        ST_PAREN   = 3'd5,
        ST_HELD    = 3'd6,
        ST_ESC_PAR = 3'd7
    } t_stage;

    function automatic logic is_kanji_final(input t_byte b);
        return (b == CH_B) || (b == CH_AT);
    endfunction

    function automatic logic is_roman_final(input t_byte b);
        return (b == CH_J) || (b == CH_B) || (b == CH_H);
    endfunction

endpackage

[rtl/jer_in_if.sv]
// jer_in_if: input byte channel, valid/ready handshake
// depends on jer_pkg

interface jer_in_if;
    import jer_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/jer_out_if.sv]
// jer_out_if: repaired byte channel with group-last flag, valid/ready handshake
// depends on jer_pkg

interface jer_out_if;
    import jer_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[rtl/jis_escape_repair.sv]
// jis_escape_repair: a request's first output byte appears in the cycle after it is taken.
// each request yields 0 to 3 bytes, drained from a 3-entry group register one per cycle
// while the sink is ready; a new request is taken in the cycle the last byte of the current
// group leaves: a request per cycle while each gives at most one byte and the sink is ready.
// synchronous active-low reset returns to one-byte mode, nothing pending, output empty.
// depends on jer_pkg, jer_in_if, jer_out_if

module jis_escape_repair (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jer_in_if.sink    i_in,
    jer_out_if.source o_out
);
    import jer_pkg::*;

    t_stage   r_stage, n_stage;
    logic     r_mode, n_mode;
    t_byte    r_held, n_held;

    t_byte    r_grp [GRP_DEPTH];
    t_grp_cnt r_cnt;

    t_byte    g_byte [GRP_DEPTH];
    t_grp_cnt g_cnt;

    logic     in_acc, out_acc;
    t_byte    b;

    assign b       = i_in.in_byte;
    assign out_acc = o_out.valid && o_out.ready;
    // take a new request once the current group is gone or its last byte leaves now
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign in_acc  = i_in.valid && i_in.ready;

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_grp[0];
    assign o_out.last     = (r_cnt == 2'd1);

    always_comb begin
        n_stage   = r_stage;
        n_mode    = r_mode;
        n_held    = r_held;
        g_cnt     = 2'd0;
        g_byte[0] = b;
        g_byte[1] = b;
        g_byte[2] = b;
        case (r_stage)
            ST_IDLE: begin
                if (r_mode) begin
                    if (b == CH_ESC) begin
                        n_stage = ST_ESC2;
                    end else if (b == CH_PAREN) begin
                        n_stage = ST_PAREN;
                    end else begin
                        n_held  = b;
                        n_stage = ST_HELD;
                    end
                end else begin
                    if (b == CH_ESC) begin
                        n_stage = ST_ESC1;
                    end else if (b == CH_DOLLAR) begin
                        n_stage = ST_DOLLAR;
                    end else begin
                        g_cnt = 2'd1;
                    end
                end
            end
            ST_ESC1: begin
                if (b == CH_DOLLAR) begin
                    n_stage = ST_ESC_DOL;
                end else begin
                    g_byte[0] = CH_ESC;
                    g_cnt     = 2'd2;
                    n_stage   = ST_IDLE;
                end
            end
            ST_DOLLAR: begin
                // bare '$' restored to a full escape when the final byte fits
                if (is_kanji_final(b)) begin
                    n_mode    = 1'b1;
                    g_byte[0] = CH_ESC;
                    g_byte[1] = CH_DOLLAR;
                    g_cnt     = 2'd3;
                end else begin
                    g_byte[0] = CH_DOLLAR;
                    g_cnt     = 2'd2;
                end
                n_stage = ST_IDLE;
            end
            ST_ESC_DOL: begin
                if (is_kanji_final(b)) begin
                    n_mode = 1'b1;
                end
                g_byte[0] = CH_ESC;
                g_byte[1] = CH_DOLLAR;
                g_cnt     = 2'd3;
                n_stage   = ST_IDLE;
            end
            ST_ESC2: begin
                if (b == CH_PAREN) begin
                    n_stage = ST_ESC_PAR;
                end else begin
                    g_byte[0] = CH_ESC;
                    g_cnt     = 2'd2;
                    n_stage   = ST_IDLE;
                end
            end
            ST_PAREN: begin
                if (is_roman_final(b)) begin
                    n_mode    = 1'b0;
                    g_byte[0] = CH_ESC;
                    g_byte[1] = CH_PAREN;
                    g_cnt     = 2'd3;
                end else begin
                    g_byte[0] = CH_PAREN;
                    g_cnt     = 2'd2;
                end
                n_stage = ST_IDLE;
            end
            ST_HELD: begin
                g_byte[0] = r_held;
                g_cnt     = 2'd2;
                n_stage   = ST_IDLE;
            end
            ST_ESC_PAR: begin
                if (is_roman_final(b)) begin
                    n_mode = 1'b0;
                end
                g_byte[0] = CH_ESC;
                g_byte[1] = CH_PAREN;
                g_cnt     = 2'd3;
                n_stage   = ST_IDLE;
            end
            default: begin
                n_stage = ST_IDLE;
            end
        endcase
        // bytes sit left-aligned: byte 1 of a two-byte group is the input
        if (g_cnt == 2'd2) begin
            g_byte[1] = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            r_mode  <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (in_acc) begin
            r_stage <= n_stage;
            r_mode  <= n_mode;
            r_cnt   <= g_cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held <= n_held;
            r_grp  <= g_byte;
        end else if (out_acc) begin
            r_grp[0] <= r_grp[1];
            r_grp[1] <= r_grp[2];
        end
    end

endmodule

[rtl/jer_checker.sv]
// jer_checker: port-level checks for jis_escape_repair, attached by bind
// depends on jis_escape_repair and its channel interfaces

module jer_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("output byte changed while stalled");

    // reset empties the output group
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty output side always takes a request
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a request is taken over a busy output only as its last byte leaves
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_valid |-> i_out_ready && i_out_last)
        else $error("request taken in middle of a group");

    // a group drains without gaps
    a_grp_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside an output group");

endmodule

bind jis_escape_repair jer_checker u_jer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

[bench/testbench.sv]
// testbench for jis_escape_repair: byte stream in, repaired bytes with group-last flag out
// depends on jer_pkg, jer_in_if, jer_out_if and the jis_escape_repair rtl
// a scoreboard class predicts each repaired byte group, a task drives the input handshake
`timescale 1ns / 1ps

import jer_pkg::*;

typedef struct packed {
    t_byte out_byte;
    logic  last;
} t_repaired;

class repair_scoreboard;
    bit          kanji_mode;
    t_stage      stage;
    t_byte       lead_byte;
    t_repaired   repaired_q[$];
    int          n_requests;
    int          n_results;
    int          n_errors;
    int          n_shift_in;
    int          n_shift_out;

    function new();
        kanji_mode  = 1'b0;
        stage       = ST_IDLE;
        lead_byte   = '0;
        n_requests  = 0;
        n_results   = 0;
        n_errors    = 0;
        n_shift_in  = 0;
        n_shift_out = 0;
    endfunction

    function void enter_kanji();
        kanji_mode = 1'b1;
        n_shift_in++;
    endfunction

    function void leave_kanji();
        kanji_mode = 1'b0;
        n_shift_out++;
    endfunction

    // advance the repair state by one request and queue the bytes it releases
    function void note_request(t_byte b);
        t_byte grp[$];
        bit    kanji_final;
        bit    roman_final;
        kanji_final = (b == CH_B) || (b == CH_AT);
        roman_final = (b == CH_J) || (b == CH_B) || (b == CH_H);
        n_requests++;
        case (stage)
            ST_IDLE: begin
                if (kanji_mode) begin
                    if (b == CH_ESC) stage = ST_ESC2;
                    else if (b == CH_PAREN) stage = ST_PAREN;
                    else begin
                        lead_byte = b;
                        stage     = ST_HELD;
                    end
                end else begin
                    if (b == CH_ESC) stage = ST_ESC1;
                    else if (b == CH_DOLLAR) stage = ST_DOLLAR;
                    else grp.push_back(b);
                end
            end
            ST_ESC1: begin
                if (b == CH_DOLLAR) stage = ST_ESC_DOL;
                else begin
                    grp = '{CH_ESC, b};
                    stage = ST_IDLE;
                end
            end
            ST_DOLLAR: begin
                // stripped escape gets restored
                if (kanji_final) begin
                    enter_kanji();
                    grp.push_back(CH_ESC);
                end
                grp.push_back(CH_DOLLAR);
                grp.push_back(b);
                stage = ST_IDLE;
            end
            ST_ESC_DOL: begin
                if (kanji_final) enter_kanji();
                grp = '{CH_ESC, CH_DOLLAR, b};
                stage = ST_IDLE;
            end
            ST_ESC2: begin
                if (b == CH_PAREN) stage = ST_ESC_PAR;
                else begin
                    grp = '{CH_ESC, b};
                    stage = ST_IDLE;
                end
            end
            ST_PAREN: begin
                if (roman_final) begin
                    leave_kanji();
                    grp.push_back(CH_ESC);
                end
                grp.push_back(CH_PAREN);
                grp.push_back(b);
                stage = ST_IDLE;
            end
            ST_HELD: begin
                // second byte of a pair is never looked at
                grp = '{lead_byte, b};
                stage = ST_IDLE;
            end
            ST_ESC_PAR: begin
                if (roman_final) leave_kanji();
                grp = '{CH_ESC, CH_PAREN, b};
                stage = ST_IDLE;
            end
        endcase
        foreach (grp[i]) repaired_q.push_back('{grp[i], i == grp.size() - 1});
    endfunction

    function void report(string what, t_byte exp_b, logic exp_l, t_byte got_b, logic got_l);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch (%s) at %0t: expected byte %h last %b, got byte %h last %b",
                     what, $realtime, exp_b, exp_l, got_b, got_l);
    endfunction

    function void check_result(t_byte b, logic last);
        t_repaired want;
        n_results++;
        if (repaired_q.size() == 0) begin
            report("unexpected byte", 'x, 'x, b, last);
            return;
        end
        want = repaired_q.pop_front();
        if (b !== want.out_byte) report("out_byte", want.out_byte, want.last, b, last);
        if (last !== want.last) report("last", want.out_byte, want.last, b, last);
    endfunction
endclass

module testbench;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int N_REQUESTS   = 280;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady;
    int   stall_cycles;

    jer_in_if  in_if ();
    jer_out_if out_if ();

    repair_scoreboard sb = new();

    jis_escape_repair dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // sink side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // results are checked before the request of the same edge is noted:
    // a result can only come from an earlier request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) sb.check_result(out_if.out_byte, out_if.last);
            if (in_if.valid && in_if.ready) sb.note_request(in_if.in_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic push_byte(input t_byte b);
        while (!steady && $urandom_range(0, 99) < 8) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= t_byte'($urandom);
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // ordinary text byte: never starts a shift sequence
    function automatic t_byte text_byte();
        t_byte b;
        do b = ($urandom_range(0, 3) == 0) ? t_byte'($urandom)
                                           : t_byte'($urandom_range(8'h20, 8'h7E));
        while (b == CH_ESC || b == CH_DOLLAR);
        return b;
    endfunction

    // first byte of a two-byte character
    function automatic t_byte lead_byte();
        t_byte b;
        do b = ($urandom_range(0, 3) == 0) ? t_byte'($urandom)
                                           : t_byte'($urandom_range(8'h21, 8'h7E));
        while (b == CH_ESC || b == CH_PAREN);
        return b;
    endfunction

    // one piece of stream chosen to suit the current mode, mostly well formed
    task automatic send_segment();
        t_byte seg[$];
        t_byte fin;
        int    pick;
        int    n;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 6);
        if (!sb.kanji_mode) begin
            if (pick < 45) repeat (n) seg.push_back(text_byte());
            else if (pick < 75) begin
                fin = $urandom_range(0, 1) ? CH_B : CH_AT;
                if ($urandom_range(0, 1)) seg = '{CH_ESC, CH_DOLLAR, fin};
                else seg = '{CH_DOLLAR, fin};
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0: seg = '{CH_ESC, t_byte'($urandom)};
                    1: seg = '{CH_ESC, CH_DOLLAR, t_byte'($urandom)};
                    default: seg = '{CH_DOLLAR, t_byte'($urandom)};
                endcase
            end else repeat ($urandom_range(1, 3)) seg.push_back(t_byte'($urandom));
        end else begin
            if (pick < 50) repeat ((n + 1) / 2) begin
                seg.push_back(lead_byte());
                seg.push_back(t_byte'($urandom));
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0: fin = CH_J;
                    1: fin = CH_B;
                    default: fin = CH_H;
                endcase
                if ($urandom_range(0, 1)) seg = '{CH_ESC, CH_PAREN, fin};
                else seg = '{CH_PAREN, fin};
            end else if (pick < 90) begin
                case ($urandom_range(0, 2))
                    0: seg = '{CH_ESC, t_byte'($urandom)};
                    1: seg = '{CH_ESC, CH_PAREN, t_byte'($urandom)};
                    default: seg = '{CH_PAREN, t_byte'($urandom)};
                endcase
            end else repeat ($urandom_range(1, 3)) seg.push_back(t_byte'($urandom));
        end
        foreach (seg[i]) push_byte(seg[i]);
    endtask

    initial begin
        t_byte directed[$];
        int    calm_from;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        directed = '{
            8'hFF,                        // plain byte in one-byte mode
            CH_DOLLAR, CH_B,              // stripped shift into two-byte mode
            8'h00, CH_PAREN,              // pair whose second byte looks like a shift
            CH_ESC, 8'h7F,                // escape then junk in two-byte mode
            CH_PAREN, 8'h41,              // bare paren with unknown final
            CH_ESC, CH_PAREN, 8'h51,      // intact escape, unknown final, mode kept
            CH_PAREN, CH_H,               // stripped shift back to one-byte mode
            CH_ESC, 8'h5A,                // escape then junk in one-byte mode
            CH_ESC, CH_DOLLAR, 8'h51,     // intact escape, unknown final
            CH_DOLLAR, 8'h41,             // bare dollar with unknown final
            CH_ESC, CH_DOLLAR, CH_AT,     // intact shift in
            CH_ESC, CH_PAREN, CH_J        // intact shift out
        };
        steady = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) push_byte(directed[i]);

        calm_from = sb.n_requests + $urandom_range(40, 120);
        while (sb.n_requests < N_REQUESTS) begin
            steady = (sb.n_requests >= calm_from) && (sb.n_requests < calm_from + 60);
            send_segment();
        end
        steady = 1'b0;
        in_if.valid <= 1'b0;

        while (sb.repaired_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.repaired_q.size() != 0) begin
            sb.n_errors++;
            $display("%0d repaired bytes never arrived", sb.repaired_q.size());
        end
        $display("stream of %0d bytes repaired into %0d bytes, %0d mismatches",
                 sb.n_requests, sb.n_results, sb.n_errors);
        $display("mode changes seen: %0d into two-byte mode, %0d back to one-byte mode",
                 sb.n_shift_in, sb.n_shift_out);
        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
